FILE: src/klt_pkg.sv
// Shared types and constants for the keyed lock table.
`default_nettype none

package klt_pkg;

    localparam int ID_W      = 31;
    localparam int CNT_W     = 8;
    localparam int SLOT_W    = 4;
    localparam int STATUS_W  = 3;
    localparam int SLOTS_DEF = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED  = 3'd0,
        STAT_QUEUED   = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_HANDED   = 3'd3,
        STAT_RELEASED = 3'd4,
        STAT_NOTFOUND = 3'd5
    } status_t;

    typedef enum logic {
        CMD_LOCK   = 1'b0,
        CMD_UNLOCK = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } state_t;

    typedef struct packed {
        cmd_t            command;
        logic [ID_W-1:0] lock_id;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0]  waiters_left;
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } res_t;

endpackage

`default_nettype wire

FILE: src/keyed_lock_table.sv
// Top level of the keyed lock table: stream ports and result register.
`default_nettype none

// Lock manager over SLOTS table entries keyed by a nonzero 31-bit lock id. Each request
// locks or unlocks one id and yields exactly one response. A request with id 0 is answered
// without a scan; any other request scans the slot memory one entry per cycle until the id is
// found or the table ends, then writes back; the slot memory has a single read port. One
// request is in work at a time, and the next request is taken while a finished response
// still waits in the output register. Reset frees every entry at once; no clearing pass.
module keyed_lock_table #(
    parameter int SLOTS = klt_pkg::SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] lock_id, [31] zero
    input  wire logic        s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // [2:0] status, [6:3] slot, [14:7] waiters_left, [15] zero
);

    klt_pkg::req_t req;
    klt_pkg::res_t res;
    klt_pkg::res_t out_reg;
    logic          out_valid_reg;
    logic          res_valid;
    logic          res_ready;

    assign req.command = klt_pkg::cmd_t'(s_tuser);
    assign req.lock_id = s_tdata[klt_pkg::ID_W-1:0];

    klt_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule

`default_nettype wire

FILE: src/klt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module klt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/klt_engine.sv
// Request sequencer: table scan, read-modify-write of the slot memory, busy flags.
`default_nettype none

module klt_engine #(
    parameter int SLOTS = klt_pkg::SLOTS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire klt_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output klt_pkg::res_t      res
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW = klt_pkg::ID_W + klt_pkg::CNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    klt_pkg::state_t state_reg, state_next;
    klt_pkg::req_t   req_reg;
    klt_pkg::res_t   res_reg, res_next;

    logic [IW-1:0]             scan_idx_reg;
    logic                      issue_reg;
    logic                      cmp_valid_reg;
    logic [IW-1:0]             cmp_idx_reg;
    logic                      hit_reg;
    logic [IW-1:0]             hit_idx_reg;
    logic [klt_pkg::CNT_W-1:0] hit_cnt_reg;
    logic                      free_found_reg;
    logic [IW-1:0]             free_idx_reg;
    logic [SLOTS-1:0]          busy_reg, busy_next;

    logic                      ram_we;
    logic [IW-1:0]             ram_waddr;
    logic [DW-1:0]             ram_wdata;
    logic                      ram_re;
    logic [DW-1:0]             ram_rdata;
    logic [klt_pkg::ID_W-1:0]  rd_key;
    logic [klt_pkg::CNT_W-1:0] rd_cnt;
    logic                      cmp_match;
    logic                      cmp_last;
    logic                      zero_id;

    klt_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[DW-1:klt_pkg::CNT_W];
    assign rd_cnt    = ram_rdata[klt_pkg::CNT_W-1:0];
    assign cmp_match = cmp_valid_reg && busy_reg[cmp_idx_reg] && (rd_key == req_reg.lock_id);
    assign cmp_last  = cmp_valid_reg && (cmp_idx_reg == LAST_IDX);
    assign zero_id   = (req.lock_id == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            klt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = zero_id ? klt_pkg::S_DONE : klt_pkg::S_SCAN;
                end
            end
            klt_pkg::S_SCAN:
            begin
                if (cmp_match || cmp_last)
                begin
                    state_next = klt_pkg::S_UPDATE;
                end
            end
            klt_pkg::S_UPDATE:
            begin
                state_next = klt_pkg::S_DONE;
            end
            klt_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = klt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = klt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = (state_reg == klt_pkg::S_IDLE);
        res_valid = (state_reg == klt_pkg::S_DONE);
        ram_re    = (state_reg == klt_pkg::S_SCAN) && issue_reg;
        res       = res_reg;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = hit_idx_reg;
        ram_wdata = {req_reg.lock_id, hit_cnt_reg};
        busy_next = busy_reg;
        res_next  = res_reg;
        if (state_reg == klt_pkg::S_IDLE)
        begin
            res_next.status       = klt_pkg::STAT_NOTFOUND;
            res_next.slot         = '0;
            res_next.waiters_left = '0;
        end
        else if (state_reg == klt_pkg::S_UPDATE)
        begin
            res_next.status       = klt_pkg::STAT_NOTFOUND;
            res_next.slot         = '0;
            res_next.waiters_left = '0;
            if (req_reg.command == klt_pkg::CMD_LOCK)
            begin
                if (hit_reg)
                begin
                    res_next.slot = klt_pkg::SLOT_W'(hit_idx_reg);
                    if (hit_cnt_reg == klt_pkg::CNT_MAX)
                    begin
                        res_next.status       = klt_pkg::STAT_FULL;
                        res_next.waiters_left = hit_cnt_reg;
                    end
                    else
                    begin
                        ram_we                = 1'b1;
                        ram_wdata             = {req_reg.lock_id, hit_cnt_reg + klt_pkg::CNT_ONE};
                        res_next.status       = klt_pkg::STAT_QUEUED;
                        res_next.waiters_left = hit_cnt_reg + klt_pkg::CNT_ONE;
                    end
                end
                else if (free_found_reg)
                begin
                    ram_we                  = 1'b1;
                    ram_waddr               = free_idx_reg;
                    ram_wdata               = {req_reg.lock_id, klt_pkg::CNT_ONE};
                    busy_next[free_idx_reg] = 1'b1;
                    res_next.status         = klt_pkg::STAT_GRANTED;
                    res_next.slot           = klt_pkg::SLOT_W'(free_idx_reg);
                    res_next.waiters_left   = klt_pkg::CNT_ONE;
                end
                else
                begin
                    res_next.status = klt_pkg::STAT_FULL;
                end
            end
            else if (hit_reg)
            begin
                res_next.slot = klt_pkg::SLOT_W'(hit_idx_reg);
                if (hit_cnt_reg > klt_pkg::CNT_ONE)
                begin
                    ram_we                = 1'b1;
                    ram_wdata             = {req_reg.lock_id, hit_cnt_reg - klt_pkg::CNT_ONE};
                    res_next.status       = klt_pkg::STAT_HANDED;
                    res_next.waiters_left = hit_cnt_reg - klt_pkg::CNT_ONE;
                end
                else
                begin
                    busy_next[hit_idx_reg] = 1'b0;
                    res_next.status        = klt_pkg::STAT_RELEASED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= klt_pkg::S_IDLE;
            busy_reg       <= '0;
            issue_reg      <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            if (state_reg == klt_pkg::S_IDLE)
            begin
                issue_reg      <= 1'b1;
                cmp_valid_reg  <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (state_reg == klt_pkg::S_SCAN)
            begin
                cmp_valid_reg <= issue_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    issue_reg <= 1'b0;
                end
                if (cmp_match)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmp_valid_reg && !busy_reg[cmp_idx_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (state_reg == klt_pkg::S_IDLE)
        begin
            req_reg      <= req;
            scan_idx_reg <= '0;
        end
        else if (state_reg == klt_pkg::S_SCAN)
        begin
            cmp_idx_reg <= scan_idx_reg;
            if (issue_reg && (scan_idx_reg != LAST_IDX))
            begin
                scan_idx_reg <= scan_idx_reg + IW'(1);
            end
            if (cmp_match)
            begin
                hit_idx_reg <= cmp_idx_reg;
                hit_cnt_reg <= rd_cnt;
            end
            if (cmp_valid_reg && !busy_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

endmodule

`default_nettype wire
